/* rtl/core/lis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lis_pkg;

	// table geometry
	localparam int unsigned MAX_LEN = 1024;
	localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
	localparam int unsigned CNT_W   = ADDR_W + 1;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned LEN_W   = 11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESULT
	} state_t;

	// one result beat handed from the controller to the output register
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             overflow;
	} res_t;

endpackage

`default_nettype wire

/* rtl/core/lis_tail_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lis_tail_ram #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/lis_search_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lis_search_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [lis_pkg::DATA_W-1:0] sample_value,
	input  logic                              start_sequence,
	output logic                              ram_wr_en,
	output logic [lis_pkg::ADDR_W-1:0]        ram_wr_addr,
	output logic [lis_pkg::DATA_W-1:0]        ram_wr_data,
	output logic                              ram_rd_en,
	output logic [lis_pkg::ADDR_W-1:0]        ram_rd_addr,
	input  logic [lis_pkg::DATA_W-1:0]        ram_rd_data,
	output logic                              res_valid,
	input  logic                              res_take,
	output lis_pkg::res_t                     res
);

	lis_pkg::state_t state_q, state_d;

	logic [lis_pkg::CNT_W-1:0]         count_q, count_d;
	logic                              ovf_q, ovf_d;
	logic signed [lis_pkg::DATA_W-1:0] last_q, last_d;
	logic signed [lis_pkg::DATA_W-1:0] key_q, key_d;
	logic [lis_pkg::ADDR_W-1:0]        lo_q, lo_d;
	logic [lis_pkg::ADDR_W-1:0]        hi_q, hi_d;
	logic [lis_pkg::ADDR_W-1:0]        mid_q, mid_d;

	logic [lis_pkg::CNT_W-1:0]  cnt_eff;
	logic                       ovf_eff;
	logic [lis_pkg::CNT_W-1:0]  top_idx;
	logic [lis_pkg::ADDR_W-1:0] nlo, nhi, nmid, span;
	logic                       probe_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lis_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_d;
		key_q  <= key_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		mid_q  <= mid_d;
	end

	// search step: narrow the window on the probe just read
	always_comb begin
		probe_ge = $signed(ram_rd_data) >= key_q;
		nlo      = probe_ge ? lo_q : mid_q + lis_pkg::ADDR_W'(1);
		nhi      = probe_ge ? mid_q : hi_q;
		span     = nhi - nlo;
		nmid     = nlo + (span >> 1);
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		ovf_d       = ovf_q;
		last_d      = last_q;
		key_d       = key_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = key_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = mid_q;
		in_stall    = 1'b1;
		res_valid   = 1'b0;
		cnt_eff     = start_sequence ? '0 : count_q;
		ovf_eff     = start_sequence ? 1'b0 : ovf_q;
		top_idx     = cnt_eff - lis_pkg::CNT_W'(1);

		unique case (state_q)
			lis_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					key_d       = sample_value;
					ram_wr_data = sample_value;
					count_d     = cnt_eff;
					ovf_d       = ovf_eff;
					state_d     = lis_pkg::ST_RESULT;
					if (cnt_eff == '0) begin
						// empty table: first tail
						ram_wr_en   = 1'b1;
						ram_wr_addr = '0;
						count_d     = lis_pkg::CNT_W'(1);
						last_d      = sample_value;
					end else if (sample_value > last_q) begin
						if (cnt_eff < lis_pkg::CNT_W'(lis_pkg::MAX_LEN)) begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = cnt_eff[lis_pkg::ADDR_W-1:0];
							count_d     = cnt_eff + lis_pkg::CNT_W'(1);
							last_d      = sample_value;
						end else begin
							// table full: drop and flag
							ovf_d = 1'b1;
						end
					end else if (top_idx == '0) begin
						// single entry, replace it directly
						ram_wr_en   = 1'b1;
						ram_wr_addr = '0;
						last_d      = sample_value;
					end else begin
						lo_d        = '0;
						hi_d        = top_idx[lis_pkg::ADDR_W-1:0];
						mid_d       = top_idx[lis_pkg::ADDR_W:1];
						ram_rd_en   = 1'b1;
						ram_rd_addr = top_idx[lis_pkg::ADDR_W:1];
						state_d     = lis_pkg::ST_SEARCH;
					end
				end
			end
			lis_pkg::ST_SEARCH: begin
				lo_d  = nlo;
				hi_d  = nhi;
				mid_d = nmid;
				if (nlo == nhi) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = nlo;
					if ({1'b0, nlo} == count_q - lis_pkg::CNT_W'(1)) begin
						last_d = key_q;
					end
					state_d = lis_pkg::ST_RESULT;
				end else begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = nmid;
				end
			end
			lis_pkg::ST_RESULT: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = lis_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lis_pkg::ST_IDLE;
			end
		endcase
	end

	assign res.length   = count_q[lis_pkg::LEN_W-1:0];
	assign res.overflow = ovf_q;

endmodule

`default_nettype wire

/* rtl/core/lis_length_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// streaming longest strictly increasing subsequence length
// input channel: in_valid / in_stall with sample_value (signed) and start_sequence;
//   start_sequence clears the length and the overflow flag before the sample is taken
// output channel: out_valid / out_stall with current_length and overflow_flag,
//   exactly one result beat for every input beat, in order
// a table of smallest tails (1024 x 32) lives in a single-port-write, single-port-read
//   synchronous ram; the last tail is also kept in a register for the append check
// flow: an append, a first sample or a dropped sample goes from its accept straight to
//   the result state and moves into the output register once that register frees; the
//   controller then returns to idle for the next beat; a replacement first runs a binary
//   search over the entries below the length at one ram probe per cycle
// throughput: one item in flight; the next beat is accepted once the previous result has
//   moved into the output register, so the rate depends on the search and on out_stall
// stall: while out_stall holds a result, a new beat is still accepted and searched; the
//   controller then waits with its result until the output register frees up
// reset: arst_n clears the length, the overflow flag, the controller state and out_valid;
//   the tail table itself is not cleared, only entries below the length are ever read

module lis_length_tracker_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [lis_pkg::DATA_W-1:0] sample_value,
	input  logic                              start_sequence,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lis_pkg::LEN_W-1:0]         current_length,
	output logic                              overflow_flag
);

	logic                       ram_wr_en;
	logic [lis_pkg::ADDR_W-1:0] ram_wr_addr;
	logic [lis_pkg::DATA_W-1:0] ram_wr_data;
	logic                       ram_rd_en;
	logic [lis_pkg::ADDR_W-1:0] ram_rd_addr;
	logic [lis_pkg::DATA_W-1:0] ram_rd_data;

	logic          res_valid;
	logic          res_take;
	lis_pkg::res_t res;

	logic          out_valid_q;
	lis_pkg::res_t out_q;

	// tail table
	lis_tail_ram #(
		.DEPTH (lis_pkg::MAX_LEN),
		.WIDTH (lis_pkg::DATA_W)
	) u_tail_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// append / search / replace sequencer, holds length and overflow
	lis_search_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.start_sequence (start_sequence),
		.ram_wr_en      (ram_wr_en),
		.ram_wr_addr    (ram_wr_addr),
		.ram_wr_data    (ram_wr_data),
		.ram_rd_en      (ram_rd_en),
		.ram_rd_addr    (ram_rd_addr),
		.ram_rd_data    (ram_rd_data),
		.res_valid      (res_valid),
		.res_take       (res_take),
		.res            (res)
	);

	// output register frees when empty or when its beat leaves this cycle
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	// payload loads only with a new beat, so a stalled beat stays put
	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign current_length = out_q.length;
	assign overflow_flag  = out_q.overflow;

endmodule

`default_nettype wire

/* rtl/core/lis_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module lis_chk (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire signed [lis_pkg::DATA_W-1:0] sample_value,
	input wire                              start_sequence,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire [lis_pkg::LEN_W-1:0]         current_length,
	input wire                              overflow_flag
);

	// one item in flight: an accepted beat stalls the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted again right after a beat");

	// every result follows at least one sample, so the length is never zero
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_length != '0)
		else $error("result with zero length");

	// overflow can only be raised with the table full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_flag |->
			current_length == lis_pkg::LEN_W'(lis_pkg::MAX_LEN))
		else $error("overflow with table not full");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(current_length)
			&& $stable(overflow_flag))
		else $error("stalled result changed");

endmodule

bind lis_length_tracker_unit lis_chk u_lis_chk (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

	// scoreboard: own copy of the tail table, one expected result per accepted beat
	class lis_scoreboard;
		logic signed [lis_pkg::DATA_W-1:0] tails [lis_pkg::MAX_LEN];
		int unsigned   tail_cnt = 0;
		logic          ovf_seen = 1'b0;
		lis_pkg::res_t pending_lengths [$];
		int            errors = 0;

		function void note_sample(logic signed [lis_pkg::DATA_W-1:0] v, logic s);
			int unsigned   lo;
			int unsigned   hi;
			int unsigned   mid;
			lis_pkg::res_t r;
			if (s) begin
				tail_cnt = 0;
				ovf_seen = 1'b0;
			end
			if (tail_cnt == 0) begin
				tails[0] = v;
				tail_cnt = 1;
			end else if (v > tails[tail_cnt-1]) begin
				if (tail_cnt < lis_pkg::MAX_LEN) begin
					tails[tail_cnt] = v;
					tail_cnt++;
				end else begin
					ovf_seen = 1'b1;
				end
			end else begin
				// first tail not below the sample
				lo = 0;
				hi = tail_cnt - 1;
				while (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					if (tails[mid] >= v)
						hi = mid;
					else
						lo = mid + 1;
				end
				tails[hi] = v;
			end
			r.length   = lis_pkg::LEN_W'(tail_cnt);
			r.overflow = ovf_seen;
			pending_lengths = {pending_lengths, r};
		endfunction

		function void check_result(logic [lis_pkg::LEN_W-1:0] len, logic ovf);
			lis_pkg::res_t want;
			if (pending_lengths.size() == 0) begin
				$display("%0t: unexpected result beat, length %0d overflow %0d",
					$time, len, ovf);
				errors++;
				return;
			end
			want = pending_lengths.pop_front();
			if (want.length !== len) begin
				$display("%0t: current_length expected %0d actual %0d",
					$time, want.length, len);
				errors++;
			end
			if (want.overflow !== ovf) begin
				$display("%0t: overflow_flag expected %0d actual %0d",
					$time, want.overflow, ovf);
				errors++;
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic signed [lis_pkg::DATA_W-1:0] sample_value = '0;
	logic                              start_sequence = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [lis_pkg::LEN_W-1:0]         current_length;
	logic                              overflow_flag;

	lis_scoreboard sb = new();

	// idling per phase: none, sender, receiver, both lightly
	int send_pct_by_phase [4] = '{0, 75, 0, 6};
	int recv_pct_by_phase [4] = '{0, 0, 75, 6};
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off, requested by the stimulus, counted by the receiver
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// directed beats: extremes, empty table, equal values, restarts
	logic signed [lis_pkg::DATA_W-1:0] dir_vals [20] = '{
		32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
		32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0000,
		32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0001, 32'sh8000_0000,
		32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
		32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0000_0000, 32'sh1234_5678
	};
	logic dir_starts [20] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
	};

	lis_length_tracker_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.start_sequence (start_sequence),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.current_length (current_length),
		.overflow_flag  (overflow_flag)
	);

	always #4 clk = ~clk;

	// offer one beat, wait for the handshake, then maybe leave a gap
	task automatic send_sample(logic signed [lis_pkg::DATA_W-1:0] v, logic s);
		int gap;
		in_valid       <= 1'b1;
		sample_value   <= v;
		start_sequence <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(v, s);
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// one random run: mostly well-formed sequences, some noise
	task automatic send_random_run(output int sent);
		int                                kind;
		int                                len;
		int                                step;
		longint                            base;
		longint                            acc;
		logic signed [lis_pkg::DATA_W-1:0] v;
		logic                              s;
		kind = $urandom_range(9);
		sent = 0;
		if (kind == 0) begin
			// noise: full-width values, stray restarts
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				v = $urandom;
				s = ($urandom_range(9) == 0);
				send_sample(v, s);
				sent++;
			end
		end else if (kind <= 2) begin
			// narrow range: lots of equal values
			len = $urandom_range(1, 30);
			for (int i = 0; i < len; i++) begin
				v = $signed($urandom_range(0, 15)) - 8;
				send_sample(v, i == 0);
				sent++;
			end
		end else begin
			// rising trend with jitter: long tables and deep searches
			len  = $urandom_range(1, 80);
			step = $urandom_range(1, 8);
			base = longint'($signed($urandom));
			for (int i = 0; i < len; i++) begin
				acc = base + longint'(i) * step + $urandom_range(0, 4 * step) - 2 * step;
				v   = acc[lis_pkg::DATA_W-1:0];
				if ($urandom_range(19) == 0)
					v = $urandom;
				s = (i == 0) && ($urandom_range(3) != 0);
				send_sample(v, s);
				sent++;
			end
		end
	endtask

	// receiver: check every result beat, drive out_stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(current_length, overflow_flag);
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		int                                n;
		int                                sent;
		longint                            acc;
		logic signed [lis_pkg::DATA_W-1:0] v;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, first beat lands on the empty table after reset
		foreach (dir_vals[i])
			send_sample(dir_vals[i], dir_starts[i]);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pct_by_phase[ph];
			recv_stall_pct <= recv_pct_by_phase[ph];

			if (ph == 0) begin
				// long hold-off while beats keep coming, so the block backs up
				hold_asks <= hold_asks + 1;

				// fill the table to the top, then push past it
				acc = -64'sd2147483648 + $urandom_range(0, 1000);
				v   = acc[lis_pkg::DATA_W-1:0];
				send_sample(v, 1'b1);
				for (int i = 1; i < lis_pkg::MAX_LEN; i++) begin
					acc = acc + $urandom_range(1, 2000000);
					v   = acc[lis_pkg::DATA_W-1:0];
					send_sample(v, 1'b0);
				end
				// appends dropped on a full table raise the sticky flag
				v = lis_pkg::DATA_W'(acc + longint'($urandom_range(1, 1000)));
				send_sample(v, 1'b0);
				send_sample(32'sh7FFF_FFFF, 1'b0);
				// equal to last tail and a replacement deep in the table
				v = acc[lis_pkg::DATA_W-1:0];
				send_sample(v, 1'b0);
				send_sample(32'sh8000_0000, 1'b0);
				v = $urandom;
				send_sample(v, 1'b0);
				send_sample(32'sh7FFF_FFFF, 1'b0);
			end

			n = 0;
			while (n < 150) begin
				send_random_run(sent);
				n += sent;
			end
		end

		// drain: no more beats, receiver stops stalling
		in_valid       <= 1'b0;
		recv_stall_pct <= 0;
		while (sb.pending_lengths.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/lis_pkg.sv
rtl/core/lis_tail_ram.sv
rtl/core/lis_search_ctrl.sv
rtl/core/lis_length_tracker_unit.sv
rtl/core/lis_chk.sv
tb/tb.sv
